@@ rtl/core/htdr_pkg.sv @@
// shared types and constants for the depth-preferred hash table
`default_nettype none

package htdr_pkg;

    // number of slots, a power of two; the low key bits select the slot
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // field widths
    localparam int KEY_W = 64;
    localparam int DEPTH_W = 8;
    localparam int SCORE_W = 16;
    localparam int FLAG_W = 2;

    // item kinds
    typedef enum logic {
        OP_STORE = 1'b0,
        OP_PROBE = 1'b1
    } op_t;

    // one table slot, key in the low bits (same layout as the input tdata)
    typedef struct packed {
        logic [FLAG_W-1:0]  flag;
        logic [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0] depth;
        logic [KEY_W-1:0]   key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one result item, hit in bit 0
    typedef struct packed {
        logic [FLAG_W-1:0]  found_flag;
        logic [SCORE_W-1:0] found_score;
        logic [DEPTH_W-1:0] found_depth;
        logic               written;
        logic               hit;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int IN_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ rtl/core/hash_table_depth_replace.sv @@
// top level: depth-preferred hash table with one read-modify-write per item
// path: lookup stage with the registered ram read, then output register
// throughput: one item per cycle unless the output stalls, set by the single
// read-modify-write on the ram; reset: rst_n clears control at once, then a
// clearing pass zeros all 1024 slots, one per cycle, holding s_axis_tready low
`default_nettype none

module hash_table_depth_replace (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // key[63:0], new_depth[71:64], new_score[87:72], new_flag[89:88], zero pad
    input  wire logic [htdr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // op[0]
    input  wire logic s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // hit[0], written[1], found_depth[9:2], found_score[25:10], found_flag[27:26]
    output logic [htdr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [htdr_pkg::IDX_W-1:0] LAST_IDX =
        htdr_pkg::IDX_W'(htdr_pkg::TABLE_ENTRIES - 1);

    // clearing pass
    logic                       clearing_reg;
    logic [htdr_pkg::IDX_W-1:0] clr_idx_reg;

    // lookup stage
    logic                 s1_valid_reg;
    htdr_pkg::op_t        s1_op_reg;
    htdr_pkg::entry_t     s1_item_reg;

    // last item write, for forwarding
    logic                       fwd_valid_reg;
    logic [htdr_pkg::IDX_W-1:0] fwd_idx_reg;
    htdr_pkg::entry_t           fwd_data_reg;

    // output register
    logic              out_valid_reg;
    htdr_pkg::result_t out_reg;

    htdr_pkg::entry_t           in_item;
    logic [htdr_pkg::IDX_W-1:0] in_idx;
    logic [htdr_pkg::IDX_W-1:0] s1_idx;
    logic                       accept;
    logic                       s1_advance;
    logic [htdr_pkg::ENTRY_W-1:0] rd_data;
    htdr_pkg::entry_t           cur;
    logic                       do_write;
    logic                       item_wr;
    htdr_pkg::result_t          result;
    logic                       ram_wr_en;
    logic [htdr_pkg::IDX_W-1:0] ram_wr_addr;
    htdr_pkg::entry_t           ram_wr_data;

    // input unpacking and handshake
    assign in_item = htdr_pkg::entry_t'(s_axis_tdata[htdr_pkg::ENTRY_W-1:0]);
    assign in_idx = in_item.key[htdr_pkg::IDX_W-1:0];
    assign s1_idx = s1_item_reg.key[htdr_pkg::IDX_W-1:0];
    assign s1_advance = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !clearing_reg && (!s1_valid_reg || s1_advance);
    assign accept = s_axis_tvalid && s_axis_tready;

    // slot contents, with the write made at the read edge forwarded
    always_comb
    begin
        if (fwd_valid_reg && (fwd_idx_reg == s1_idx))
        begin
            cur = fwd_data_reg;
        end
        else
        begin
            cur = htdr_pkg::entry_t'(rd_data);
        end
    end

    // replacement decision and result
    always_comb
    begin
        do_write = (cur.key == '0) || (cur.depth <= s1_item_reg.depth);
        result = '0;
        case (s1_op_reg)
            htdr_pkg::OP_STORE:
            begin
                result.written = do_write;
            end
            htdr_pkg::OP_PROBE:
            begin
                if (cur.key == s1_item_reg.key)
                begin
                    result.hit = 1'b1;
                    result.found_depth = cur.depth;
                    result.found_score = cur.score;
                    result.found_flag = cur.flag;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    assign item_wr = s1_valid_reg && s1_advance &&
                     (s1_op_reg == htdr_pkg::OP_STORE) && do_write;

    // ram write mux: clearing pass or item write-back
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_wr_en = 1'b1;
            ram_wr_addr = clr_idx_reg;
            ram_wr_data = '0;
        end
        else
        begin
            ram_wr_en = item_wr;
            ram_wr_addr = s1_idx;
            ram_wr_data = s1_item_reg;
        end
    end

    htdr_ram #(
        .WIDTH  (htdr_pkg::ENTRY_W),
        .DEPTH  (htdr_pkg::TABLE_ENTRIES),
        .ADDR_W (htdr_pkg::IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (rd_data)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (item_wr)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_valid_reg && s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= htdr_pkg::op_t'(s_axis_tuser);
            s1_item_reg <= in_item;
        end
        if (item_wr)
        begin
            fwd_idx_reg <= s1_idx;
            fwd_data_reg <= s1_item_reg;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_reg <= result;
        end
    end

    // output
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = htdr_pkg::OUT_TDATA_W'(out_reg);

endmodule

`default_nettype wire

@@ rtl/core/htdr_ram.sv @@
// simple dual-port synchronous ram, one write and one registered read port
`default_nettype none

module htdr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, returns old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/htdr_checker.sv @@
// port-level checks for the hash table, bound to the top level
`default_nettype none

module htdr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [htdr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // the clearing pass blocks input right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !s_axis_tready)
        else $error("input ready during clearing pass");

    // a result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // hit and written never together
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("hit and written both set");

    // no hit means the found fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[27:2] == '0)
        else $error("found fields nonzero without hit");

endmodule

bind hash_table_depth_replace htdr_checker u_htdr_checker (.*);

`default_nettype wire

@@ test/htdr_checker.sv @@
// checker for the depth-preferred hash table: predicts each result item and compares
`timescale 1ns / 100ps

module htdr_scoreboard (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [htdr_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [htdr_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                               mismatches,
    output int                               outstanding
);

    // shadow copy of the table
    logic [htdr_pkg::KEY_W-1:0]   slot_key   [htdr_pkg::TABLE_ENTRIES];
    logic [htdr_pkg::DEPTH_W-1:0] slot_depth [htdr_pkg::TABLE_ENTRIES];
    logic [htdr_pkg::SCORE_W-1:0] slot_score [htdr_pkg::TABLE_ENTRIES];
    logic [htdr_pkg::FLAG_W-1:0]  slot_flag  [htdr_pkg::TABLE_ENTRIES];

    // predicted result items, oldest first
    htdr_pkg::result_t expected_results[$];

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // apply one item to the shadow table and return the result it should give
    function automatic htdr_pkg::result_t table_access(input htdr_pkg::op_t kind,
                                                       input htdr_pkg::entry_t item);
        logic [htdr_pkg::IDX_W-1:0] slot;
        htdr_pkg::result_t res;
        slot = item.key[htdr_pkg::IDX_W-1:0];
        res = '0;
        if (kind == htdr_pkg::OP_STORE)
        begin
            // empty slot or not deeper than the new entry: replace
            if (slot_key[slot] == '0 || slot_depth[slot] <= item.depth)
            begin
                slot_key[slot]   = item.key;
                slot_depth[slot] = item.depth;
                slot_score[slot] = item.score;
                slot_flag[slot]  = item.flag;
                res.written      = 1'b1;
            end
        end
        else if (slot_key[slot] == item.key)
        begin
            res.hit         = 1'b1;
            res.found_depth = slot_depth[slot];
            res.found_score = slot_score[slot];
            res.found_flag  = slot_flag[slot];
        end
        return res;
    endfunction

    // compare one result item field by field against the oldest prediction
    task automatic check_result(input htdr_pkg::result_t got);
        htdr_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result item with nothing pending: %h", got));
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.hit !== want.hit)
                report_mismatch($sformatf("hit got %0b expected %0b", got.hit, want.hit));
            if (got.written !== want.written)
                report_mismatch($sformatf("written got %0b expected %0b",
                                          got.written, want.written));
            if (got.found_depth !== want.found_depth)
                report_mismatch($sformatf("found_depth got %0d expected %0d",
                                          got.found_depth, want.found_depth));
            if (got.found_score !== want.found_score)
                report_mismatch($sformatf("found_score got %0d expected %0d",
                                          $signed(got.found_score),
                                          $signed(want.found_score)));
            if (got.found_flag !== want.found_flag)
                report_mismatch($sformatf("found_flag got %0d expected %0d",
                                          got.found_flag, want.found_flag));
        end
    endtask

    // watch both channels; the result side first since it trails the input side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < htdr_pkg::TABLE_ENTRIES; i++)
            begin
                slot_key[i]   = '0;
                slot_depth[i] = '0;
                slot_score[i] = '0;
                slot_flag[i]  = '0;
            end
            expected_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(htdr_pkg::result_t'(m_tdata[htdr_pkg::RESULT_W-1:0]));
            if (s_tvalid && s_tready)
                expected_results.push_back(
                    table_access(htdr_pkg::op_t'(s_tuser),
                                 htdr_pkg::entry_t'(s_tdata[htdr_pkg::ENTRY_W-1:0])));
            outstanding = expected_results.size();
        end
    end

endmodule

@@ test/testbench.sv @@
// top of the hash table regression: clock, reset, stimulus, backpressure and verdict
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1230;
    localparam int MAX_IDLE     = 14;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int RECENT_DEPTH = 16;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [htdr_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [htdr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int results_seen = 0;
    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;

    // keys cluster on a few slots and tags so stores and probes collide often
    logic [htdr_pkg::KEY_W-htdr_pkg::IDX_W-1:0] key_tags  [6];
    logic [htdr_pkg::IDX_W-1:0]                 hot_slots [8];
    logic [htdr_pkg::KEY_W-1:0]                 recent_keys[$];

    hash_table_depth_replace dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    htdr_scoreboard u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("hash_table_depth_replace regression: fail");
            $finish;
        end
    end

    // offer one item after a random gap and hold it until taken
    task automatic send_item(input htdr_pkg::op_t kind,
                             input logic [htdr_pkg::KEY_W-1:0] key,
                             input logic [htdr_pkg::DEPTH_W-1:0] depth,
                             input logic [htdr_pkg::SCORE_W-1:0] score,
                             input logic [htdr_pkg::FLAG_W-1:0] flag);
        htdr_pkg::entry_t item;
        int gap;
        item.key   = key;
        item.depth = depth;
        item.score = score;
        item.flag  = flag;
        gap = send_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= htdr_pkg::IN_TDATA_W'(item);
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // key from the clustered pool, now and then a fully random one
    function automatic logic [htdr_pkg::KEY_W-1:0] make_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return {$urandom, $urandom};
        if (pick < 30)
            return {key_tags[$urandom_range(0, 5)], htdr_pkg::IDX_W'($urandom)};
        return {key_tags[$urandom_range(0, 5)], hot_slots[$urandom_range(0, 7)]};
    endfunction

    // result side: random stalls, burst stretches and one long hold-off
    initial
    begin
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (results_seen % 40 == 0)
                recv_burst = ($urandom_range(0, 2) == 0);
            if (results_seen == HOLD_AT)
                stall = HOLD_CYCLES;
            else
                stall = recv_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            results_seen++;
            @(negedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [htdr_pkg::KEY_W-1:0]   key;
        logic [htdr_pkg::DEPTH_W-1:0] depth;

        key_tags[0] = '0;
        key_tags[1] = '1;
        for (int i = 2; i < 6; i++)
            key_tags[i] = {$urandom, $urandom};
        hot_slots[0] = '0;
        hot_slots[1] = '1;
        for (int i = 2; i < 8; i++)
            hot_slots[i] = htdr_pkg::IDX_W'($urandom);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table: key zero reads as a hit of zeros, other keys miss
        send_item(htdr_pkg::OP_PROBE, 64'h0, 8'd0, 16'h0, 2'd0);
        send_item(htdr_pkg::OP_PROBE, 64'h5, 8'd0, 16'h0, 2'd0);
        send_item(htdr_pkg::OP_STORE, 64'h0, 8'd0, 16'h0, 2'd0);
        send_item(htdr_pkg::OP_PROBE, 64'h0, 8'd0, 16'h0, 2'd0);
        // top slot, largest fields, unused flag code
        send_item(htdr_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 16'h7FFF, 2'd3);
        send_item(htdr_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'h0, 2'd0);
        // shallower store refused, equal depth replaces
        send_item(htdr_pkg::OP_STORE, 64'h8000_0000_0000_03FF, 8'd254, 16'h1234, 2'd1);
        send_item(htdr_pkg::OP_STORE, 64'h8000_0000_0000_03FF, 8'd255, 16'h8000, 2'd2);
        send_item(htdr_pkg::OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'h0, 2'd0);
        send_item(htdr_pkg::OP_PROBE, 64'h8000_0000_0000_03FF, 8'd0, 16'h0, 2'd0);
        // collision on slot 5
        send_item(htdr_pkg::OP_STORE, 64'h1234_5678_9ABC_D405, 8'd10, 16'h8000, 2'd1);
        send_item(htdr_pkg::OP_STORE, 64'h0000_0000_0000_0405, 8'd9, 16'h7FFF, 2'd2);
        send_item(htdr_pkg::OP_STORE, 64'h0000_0000_0000_0405, 8'd10, 16'hFFFF, 2'd2);
        send_item(htdr_pkg::OP_PROBE, 64'h1234_5678_9ABC_D405, 8'd0, 16'h0, 2'd0);
        send_item(htdr_pkg::OP_PROBE, 64'h0000_0000_0000_0405, 8'd0, 16'h0, 2'd0);
        // slot holding key zero counts as empty
        send_item(htdr_pkg::OP_STORE, 64'h400, 8'd0, 16'h0001, 2'd1);
        send_item(htdr_pkg::OP_PROBE, 64'h0, 8'd0, 16'h0, 2'd0);
        send_item(htdr_pkg::OP_STORE, 64'h0, 8'd0, 16'hFFFE, 2'd3);
        send_item(htdr_pkg::OP_PROBE, 64'h400, 8'd0, 16'h0, 2'd0);
        send_item(htdr_pkg::OP_PROBE, 64'h0, 8'd0, 16'h0, 2'd0);

        // random part: stores and probes on colliding keys, probes favor recent stores
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                send_burst = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 1) == 1)
            begin
                if (recent_keys.size() > 0 && $urandom_range(0, 9) < 6)
                    key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else
                    key = make_key();
                send_item(htdr_pkg::OP_PROBE, key, htdr_pkg::DEPTH_W'($urandom),
                          htdr_pkg::SCORE_W'($urandom), htdr_pkg::FLAG_W'($urandom));
            end
            else
            begin
                if (recent_keys.size() > 0 && $urandom_range(0, 9) < 3)
                    key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else
                    key = make_key();
                if ($urandom_range(0, 2) == 0)
                    depth = htdr_pkg::DEPTH_W'($urandom_range(0, 3));
                else
                    depth = htdr_pkg::DEPTH_W'($urandom_range(0, 255));
                send_item(htdr_pkg::OP_STORE, key, depth, htdr_pkg::SCORE_W'($urandom),
                          htdr_pkg::FLAG_W'($urandom_range(0, 3)));
                recent_keys.push_back(key);
                if (recent_keys.size() > RECENT_DEPTH)
                    void'(recent_keys.pop_front());
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then a few cycles for anything stray
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("hash_table_depth_replace regression: pass");
        else
            $display("hash_table_depth_replace regression: fail");
        $finish;
    end

endmodule

@@ hash_table_depth_replace.f @@
rtl/core/htdr_pkg.sv
rtl/core/htdr_ram.sv
rtl/core/hash_table_depth_replace.sv
rtl/core/htdr_checker.sv
test/htdr_checker.sv
test/testbench.sv
